/* src/fed_pkg.sv */
// Package for the allocation table entry locator and decoder.
// Holds the widths, table format codes, register indexes and pipeline types.
// No dependencies; used by the channel interfaces and the top level.
package fed_pkg;

  localparam int CLUSTER_W  = 28;
  localparam int RAW_W      = 32;
  localparam int SECTOR_W   = 32;
  localparam int BYTE_OFF_W = 12;
  localparam int START_W    = 16;
  localparam int SBYTES_W   = 13;
  localparam int CSECT_W    = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // The table offset is at most 4 * (2^28 - 1), which fits in 30 bits.
  localparam int OFFSET_W   = 30;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = OFFSET_W / DIV_BITS;
  localparam int NUM_STAGES = DIV_STAGES + 2;

  localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_FAT_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 3'd4;

  localparam logic [CLUSTER_W-1:0] EOC_MARK    = 28'hFFFFFFF;
  localparam logic [CLUSTER_W-1:0] EOC_FAT12   = 28'h0000FF8;
  localparam logic [CLUSTER_W-1:0] EOC_FAT16   = 28'h000FFF8;
  localparam logic [CLUSTER_W-1:0] EOC_FAT32   = 28'hFFFFFF8;
  localparam logic [CLUSTER_W-1:0] MASK_FAT12  = 28'h0000FFF;

  typedef struct packed {
    logic [OFFSET_W-1:0]   offset;
    logic [OFFSET_W-1:0]   dvd;
    logic [SBYTES_W-1:0]   rem;
    logic [OFFSET_W-1:0]   quot;
    logic [CLUSTER_W-1:0]  cm2;
    logic                  below2;
    logic [SECTOR_W-1:0]   first;
    logic [CLUSTER_W-1:0]  next;
    logic                  eoc;
    logic                  fat12;
    logic [SECTOR_W-1:0]   tsec;
    logic [BYTE_OFF_W-1:0] byte_off;
    logic                  straddle;
  } pipe_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]   table_sector;
    logic [BYTE_OFF_W-1:0] entry_byte_offset;
    logic                  straddles_sectors;
    logic [SECTOR_W-1:0]   cluster_first_sector;
    logic [CLUSTER_W-1:0]  chain_next;
    logic                  end_of_chain;
  } res_t;

endpackage

/* src/fed_in_if.sv */
// Input channel of the allocation table entry locator: valid, ready and one item.
// Depends on fed_pkg for the field widths.
interface fed_in_if;
  logic                           valid;
  logic                           ready;
  logic [fed_pkg::CLUSTER_W-1:0]  cluster_number;
  logic [fed_pkg::RAW_W-1:0]      raw_entry;

  modport source (output valid, output cluster_number, output raw_entry, input ready);
  modport sink   (input valid, input cluster_number, input raw_entry, output ready);
endinterface

/* src/fed_out_if.sv */
// Result channel of the allocation table entry locator: valid, ready and one item.
// Depends on fed_pkg for the field widths.
interface fed_out_if;
  logic                           valid;
  logic                           ready;
  logic [fed_pkg::SECTOR_W-1:0]   table_sector;
  logic [fed_pkg::BYTE_OFF_W-1:0] entry_byte_offset;
  logic                           straddles_sectors;
  logic [fed_pkg::SECTOR_W-1:0]   cluster_first_sector;
  logic [fed_pkg::CLUSTER_W-1:0]  chain_next;
  logic                           end_of_chain;

  modport source (output valid, output table_sector, output entry_byte_offset,
                  output straddles_sectors, output cluster_first_sector,
                  output chain_next, output end_of_chain, input ready);
  modport sink   (input valid, input table_sector, input entry_byte_offset,
                  input straddles_sectors, input cluster_first_sector,
                  input chain_next, input end_of_chain, output ready);
endinterface

/* src/fat_entry_locate_decode.sv */
// Allocation table entry locator and decoder for FAT12, FAT16 and FAT32.
// Throughput: one item per cycle while the skid register is not full. An item passes
// through the entry stage, then the 30-bit restoring divider that resolves
// 3 quotient bits per stage over 10 stages, then the finish stage and the output register.
// Reset (synchronous, rst_n low) empties the pipeline and output, and loads the
// register defaults: FAT16, table start 1, 512-byte sectors, 1 sector per cluster.
module fat_entry_locate_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  fed_in_if.sink                          in_ch,
  fed_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NS = fed_pkg::NUM_STAGES;
  localparam int DS = fed_pkg::DIV_STAGES;
  localparam int OW = fed_pkg::OFFSET_W;
  localparam int SW = fed_pkg::SBYTES_W;

  logic [fed_pkg::KIND_W-1:0]   kind_r;
  logic [fed_pkg::START_W-1:0]  tstart_r;
  logic [SW-1:0]                sbytes_r;
  logic [fed_pkg::CSECT_W-1:0]  csect_r;
  logic [fed_pkg::SECTOR_W-1:0] dstart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= fed_pkg::KIND_FAT16;
      tstart_r <= 16'd1;
      sbytes_r <= 13'd512;
      csect_r  <= 8'd1;
      dstart_r <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        fed_pkg::CFG_FAT_KIND:     kind_r   <= cfg_data[fed_pkg::KIND_W-1:0];
        fed_pkg::CFG_TABLE_START:  tstart_r <= cfg_data[fed_pkg::START_W-1:0];
        fed_pkg::CFG_SECTOR_BYTES: sbytes_r <= cfg_data[SW-1:0];
        fed_pkg::CFG_CLUSTER_SECT: csect_r  <= cfg_data[fed_pkg::CSECT_W-1:0];
        fed_pkg::CFG_DATA_START:   dstart_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fed_pkg::pipe_t  stage_r   [NS];
  fed_pkg::pipe_t  stage_nxt [NS];
  logic [NS-1:0]   v_r;
  logic            pipe_en;

  fed_pkg::res_t   out_r, skid_r, res_nxt;
  logic            out_v_r, skid_v_r;

  // The pipeline only stops when the skid register is full.
  assign pipe_en     = !skid_v_r;
  assign in_ch.ready = pipe_en;

  // Entry stage: table offset and entry decode.
  always_comb begin
    logic [fed_pkg::CLUSTER_W-1:0] c;
    logic [15:0]                   w;
    fed_pkg::pipe_t                s;
    c = in_ch.cluster_number;
    w = in_ch.raw_entry[15:0];
    s = '0;
    s.fat12  = (kind_r == fed_pkg::KIND_FAT12);
    s.below2 = (c < 28'd2);
    s.cm2    = c - 28'd2;
    case (kind_r)
      fed_pkg::KIND_FAT12: begin
        s.offset = {2'b00, c} + {3'b000, c[fed_pkg::CLUSTER_W-1:1]};
        s.next   = c[0] ? {16'd0, w[15:4]} : ({12'd0, w} & fed_pkg::MASK_FAT12);
        s.eoc    = (s.next >= fed_pkg::EOC_FAT12);
      end
      fed_pkg::KIND_FAT16: begin
        s.offset = {1'b0, c, 1'b0};
        s.next   = {12'd0, w};
        s.eoc    = (s.next >= fed_pkg::EOC_FAT16);
      end
      default: begin
        s.offset = {c, 2'b00};
        s.next   = in_ch.raw_entry[fed_pkg::CLUSTER_W-1:0];
        s.eoc    = (s.next >= fed_pkg::EOC_FAT32);
      end
    endcase
    if (s.eoc) begin
      s.next = fed_pkg::EOC_MARK;
    end
    s.dvd = s.offset;
    stage_nxt[0] = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (pipe_en) begin
      v_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      stage_r[0] <= stage_nxt[0];
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_stage
    always_comb begin
      fed_pkg::pipe_t s;
      logic [SW:0]    t;
      logic [SW:0]    diff;
      logic           ge;
      logic [35:0]    prod;
      s    = stage_r[i-1];
      t    = '0;
      diff = '0;
      ge   = 1'b0;
      prod = '0;
      if (i <= DS) begin
        // Restoring division, one quotient bit per step.
        for (int k = 0; k < fed_pkg::DIV_BITS; k++) begin
          t      = {s.rem, s.dvd[OW-1]};
          diff   = t - {1'b0, sbytes_r};
          ge     = (t >= {1'b0, sbytes_r});
          s.rem  = ge ? diff[SW-1:0] : t[SW-1:0];
          s.quot = {s.quot[OW-2:0], ge};
          s.dvd  = {s.dvd[OW-2:0], 1'b0};
        end
      end
      if (i == 1) begin
        prod    = {8'd0, s.cm2} * {28'd0, csect_r};
        s.first = prod[fed_pkg::SECTOR_W-1:0];
      end
      if (i == 2) begin
        s.first = s.below2 ? '0 : dstart_r + s.first;
      end
      if (i == NS - 1) begin
        // A zero sector size reads as an all-ones quotient and the whole offset.
        if (sbytes_r == '0) begin
          s.tsec     = {16'd0, tstart_r} + 32'hFFFF_FFFF;
          s.byte_off = s.offset[fed_pkg::BYTE_OFF_W-1:0];
          s.straddle = 1'b0;
        end else begin
          s.tsec     = {16'd0, tstart_r} + {2'b00, s.quot};
          s.byte_off = s.rem[fed_pkg::BYTE_OFF_W-1:0];
          s.straddle = s.fat12 && (s.rem == sbytes_r - 13'd1);
        end
      end
      stage_nxt[i] = s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (pipe_en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        stage_r[i] <= stage_nxt[i];
      end
    end
  end

  always_comb begin
    res_nxt.table_sector         = stage_r[NS-1].tsec;
    res_nxt.entry_byte_offset    = stage_r[NS-1].byte_off;
    res_nxt.straddles_sectors    = stage_r[NS-1].straddle;
    res_nxt.cluster_first_sector = stage_r[NS-1].first;
    res_nxt.chain_next           = stage_r[NS-1].next;
    res_nxt.end_of_chain         = stage_r[NS-1].eoc;
  end

  logic arrive, out_take;
  assign arrive   = pipe_en && v_r[NS-1];
  assign out_take = out_v_r && out_ch.ready;

  // An item that arrives while the output is stalled parks in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (arrive) begin
      if (out_v_r && !out_ch.ready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (arrive) begin
      if (out_v_r && !out_ch.ready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_ch.valid                = out_v_r;
  assign out_ch.table_sector         = out_r.table_sector;
  assign out_ch.entry_byte_offset    = out_r.entry_byte_offset;
  assign out_ch.straddles_sectors    = out_r.straddles_sectors;
  assign out_ch.cluster_first_sector = out_r.cluster_first_sector;
  assign out_ch.chain_next           = out_r.chain_next;
  assign out_ch.end_of_chain         = out_r.end_of_chain;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ch.ready) |=> skid_v_r)
    else $error("skid item dropped while the output was stalled");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (arrive && out_v_r && !out_ch.ready) |=> (skid_v_r && out_v_r))
    else $error("item arriving at a stalled output was not parked");

endmodule
